>>> rtl/core/mbcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcs_pkg
// Types, control-word bits and microcode table of the microcoded bus cpu.
// ----------------------------------------------------------------------------
package mbcs_pkg;

    localparam int RAM_DEPTH = 16;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int CW_W      = 15;

    typedef logic [CW_W-1:0]   cw_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // control bits
    localparam cw_t C_HLT = 15'h0001;
    localparam cw_t C_RI  = 15'h0002;
    localparam cw_t C_RO  = 15'h0004;
    localparam cw_t C_MI  = 15'h0008;
    localparam cw_t C_II  = 15'h0010;
    localparam cw_t C_IO  = 15'h0020;
    localparam cw_t C_BO  = 15'h0040;
    localparam cw_t C_BI  = 15'h0080;
    localparam cw_t C_SUB = 15'h0100;
    localparam cw_t C_SO  = 15'h0200;
    localparam cw_t C_AO  = 15'h0400;
    localparam cw_t C_AI  = 15'h0800;
    localparam cw_t C_CI  = 15'h1000;
    localparam cw_t C_CO  = 15'h2000;
    localparam cw_t C_CE  = 15'h4000;

    // opcodes
    localparam logic [3:0] OP_HLT = 4'h0;
    localparam logic [3:0] OP_LDA = 4'h1;
    localparam logic [3:0] OP_STA = 4'h2;
    localparam logic [3:0] OP_ADD = 4'h3;

    // item operations
    localparam logic OPER_TICK = 1'b0;
    localparam logic OPER_LOAD = 1'b1;

    typedef struct packed {
        logic       operation;
        addr_t      load_address;
        logic [7:0] load_data;
    } item_t;

    typedef struct packed {
        cw_t        control_word;
        logic [7:0] bus_value;
        logic [3:0] program_counter;
        logic [7:0] instruction;
        addr_t      memory_address;
        logic [7:0] accumulator;
        logic [7:0] operand_reg;
        logic       halted;
    } result_t;

    typedef struct packed {
        logic       en;
        addr_t      addr;
        logic [7:0] data;
    } ram_wr_t;

    function automatic cw_t urom_lookup(logic [3:0] opcode, logic [2:0] step);
        cw_t cw;
        cw = '0;
        unique case (step)
            3'd0: cw = C_CO | C_MI;
            3'd1: cw = C_RO | C_II | C_CE;
            3'd2:
            begin
                unique case (opcode) inside
                    OP_HLT:                 cw = C_HLT;
                    OP_LDA, OP_STA, OP_ADD: cw = C_IO | C_MI;
                    default:                cw = '0;
                endcase
            end
            3'd3:
            begin
                unique case (opcode)
                    OP_LDA:  cw = C_RO | C_AI;
                    OP_STA:  cw = C_AO | C_RI;
                    OP_ADD:  cw = C_RO | C_BI;
                    default: cw = '0;
                endcase
            end
            3'd4:
            begin
                unique case (opcode)
                    OP_ADD:  cw = C_SO | C_AI;
                    default: cw = '0;
                endcase
            end
            default: cw = '0;
        endcase
        return cw;
    endfunction

endpackage

>>> rtl/core/mbcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcs_ram
// Program/data RAM with a registered read port that tracks the next memory
// address, forwarding a same-cycle write and reading unwritten bytes as zero.
// ----------------------------------------------------------------------------
module mbcs_ram
    import mbcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ram_wr_t    wr,
    input  addr_t      rd_addr,
    output logic [7:0] rd_data
);

    logic [7:0]           mem [RAM_DEPTH];
    logic [RAM_DEPTH-1:0] valid_reg;
    logic [7:0]           rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_data_reg <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            // bypass a write to the entry being fetched
            if (wr.en && (wr.addr == rd_addr))
            begin
                rd_data_reg <= wr.data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/microcoded_bus_cpu_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// microcoded_bus_cpu_step_unit
// Small 8-bit microcoded bus computer, one microstep or one RAM load per word.
// ----------------------------------------------------------------------------
// usage:
//   item channel (item_valid/item_ready/item) takes a tick word or a program
//   load word; result channel (result_valid/result_ready/result) returns one
//   word per item with the control word, bus value and registers afterwards.
//   an item is executed in the cycle it is accepted; its result is
//   registered. one item per cycle is sustained while item_ready is high:
//   the ram read port is registered at the next memory address, so a tick
//   needs only the microcode lookup, the bus mux and the latches.
//   a two-entry output stage (result register plus skid) lets an item enter
//   while a result waits; item_ready drops only when both entries are full.
//   reset clears the cpu registers, the halt flag and the ram valid bits,
//   so the ram reads as all zero until written. no clearing pass is needed.
//   once halted, ticks change nothing and report a zero control word.
// ----------------------------------------------------------------------------
module microcoded_bus_cpu_step_unit
    import mbcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic [3:0] pc_reg,   pc_next;
    addr_t      mar_reg,  mar_next;
    logic [7:0] ir_reg,   ir_next;
    logic [7:0] a_reg,    a_next;
    logic [7:0] b_reg,    b_next;
    logic [2:0] step_reg, step_next;
    logic       halt_reg, halt_next;

    result_t    out_reg,  skid_reg;
    logic       out_valid_reg, skid_valid_reg;

    logic       accept, tick, pop;
    cw_t        cw;
    logic [7:0] bus;
    logic [7:0] ram_rd;
    ram_wr_t    ram_wr;
    result_t    new_result;

    assign item_ready = !skid_valid_reg;
    assign accept     = item_valid && item_ready;
    assign tick       = accept && (item.operation == OPER_TICK) && !halt_reg;
    assign pop        = out_valid_reg && result_ready;

    mbcs_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ram_wr),
        .rd_addr (mar_next),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        cw = tick ? urom_lookup(ir_reg[7:4], step_reg) : '0;

        // single bus driver, fixed priority
        if ((cw & C_CO) != '0)       bus = {4'b0, pc_reg};
        else if ((cw & C_AO) != '0)  bus = a_reg;
        else if ((cw & C_SO) != '0)  bus = a_reg + b_reg;
        else if ((cw & C_SUB) != '0) bus = a_reg - b_reg;
        else if ((cw & C_BO) != '0)  bus = b_reg;
        else if ((cw & C_IO) != '0)  bus = {4'b0, ir_reg[3:0]};
        else if ((cw & C_RO) != '0)  bus = ram_rd;
        else                         bus = '0;

        mar_next  = ((cw & C_MI) != '0) ? bus[ADDR_W-1:0] : mar_reg;
        ir_next   = ((cw & C_II) != '0) ? bus : ir_reg;
        b_next    = ((cw & C_BI) != '0) ? bus : b_reg;
        a_next    = ((cw & C_AI) != '0) ? bus : a_reg;
        if ((cw & C_CE) != '0)      pc_next = pc_reg + 4'd1;
        else if ((cw & C_CI) != '0) pc_next = bus[3:0];
        else                        pc_next = pc_reg;
        step_next = tick ? step_reg + 3'd1 : step_reg;
        halt_next = halt_reg || ((cw & C_HLT) != '0);

        if (accept && (item.operation == OPER_LOAD))
        begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = item.load_address;
            ram_wr.data = item.load_data;
        end
        else
        begin
            ram_wr.en   = (cw & C_RI) != '0;
            ram_wr.addr = mar_reg;
            ram_wr.data = bus;
        end

        new_result.control_word    = cw;
        new_result.bus_value       = bus;
        new_result.program_counter = pc_next;
        new_result.instruction     = ir_next;
        new_result.memory_address  = mar_next;
        new_result.accumulator     = a_next;
        new_result.operand_reg     = b_next;
        new_result.halted          = halt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            mar_reg  <= '0;
            ir_reg   <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            step_reg <= '0;
            halt_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            mar_reg  <= mar_next;
            ir_reg   <= ir_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            step_reg <= step_next;
            halt_reg <= halt_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= new_result;
            end
            else
            begin
                skid_reg <= new_result;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

>>> tb/microcoded_bus_cpu_step_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// microcoded_bus_cpu_step_unit_test
// Runs short programs on the bus cpu, one microstep or RAM load per word.
// Expected registers come from a cycle-level model of the cpu in this file.
// Each program segment fills a window of RAM with instructions and clocks
// through it. Stores only target addresses outside that window, so the cpu
// keeps running until a final segment halts it on purpose.
// ----------------------------------------------------------------------------
module microcoded_bus_cpu_step_unit_test;
    import mbcs_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int TARGET_WORDS = 400;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item_word;
    logic    result_valid;
    logic    result_ready;
    result_t result_word;

    microcoded_bus_cpu_step_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_word)
    );

    // cpu model state
    addr_t      pc_model;
    addr_t      mar_model;
    logic [7:0] ir_model;
    logic [7:0] a_model;
    logic [7:0] b_model;
    logic [2:0] step_model;
    logic       halt_model;
    logic [7:0] ram_model [RAM_DEPTH];

    item_t   pending_words [$];
    result_t expected_results [$];
    int      words_queued;
    int      words_accepted;
    int      words_sent;
    int      error_count;
    int      cycle_count;

    int   burst_left;
    int   gap_left;
    int   stall_left;
    int   stall_pct;
    int   mode_left;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic cw_t microcode(logic [3:0] opc, logic [2:0] stp);
        case (stp)
            3'd0: return C_CO | C_MI;
            3'd1: return C_RO | C_II | C_CE;
            3'd2:
            begin
                if (opc == OP_HLT)
                    return C_HLT;
                if (opc == OP_LDA || opc == OP_STA || opc == OP_ADD)
                    return C_IO | C_MI;
                return '0;
            end
            3'd3:
            begin
                if (opc == OP_LDA)
                    return C_RO | C_AI;
                if (opc == OP_STA)
                    return C_AO | C_RI;
                if (opc == OP_ADD)
                    return C_RO | C_BI;
                return '0;
            end
            3'd4: return (opc == OP_ADD) ? (C_SO | C_AI) : cw_t'(0);
            default: return '0;
        endcase
    endfunction

    // applies one word to the model and returns the registers afterwards
    task automatic execute_word(input item_t w, output result_t r);
        cw_t        cw;
        logic [7:0] bus;
        cw  = '0;
        bus = '0;
        if (w.operation == OPER_LOAD)
            ram_model[w.load_address] = w.load_data;
        else if (!halt_model)
        begin
            cw = microcode(ir_model[7:4], step_model);
            if ((cw & C_HLT) != 0)
                halt_model = 1'b1;
            if ((cw & C_CO) != 0)
                bus = {4'h0, pc_model};
            else if ((cw & C_AO) != 0)
                bus = a_model;
            else if ((cw & C_SO) != 0)
                bus = a_model + b_model;
            else if ((cw & C_SUB) != 0)
                bus = a_model - b_model;
            else if ((cw & C_BO) != 0)
                bus = b_model;
            else if ((cw & C_IO) != 0)
                bus = {4'h0, ir_model[3:0]};
            else if ((cw & C_RO) != 0)
                bus = ram_model[mar_model];
            if ((cw & C_RI) != 0)
                ram_model[mar_model] = bus;
            if ((cw & C_MI) != 0)
                mar_model = bus[3:0];
            if ((cw & C_II) != 0)
                ir_model = bus;
            if ((cw & C_BI) != 0)
                b_model = bus;
            if ((cw & C_AI) != 0)
                a_model = bus;
            if ((cw & C_CI) != 0)
                pc_model = bus[3:0];
            if ((cw & C_CE) != 0)
                pc_model = pc_model + 4'd1;
            step_model = step_model + 3'd1;
        end
        r.control_word    = cw;
        r.bus_value       = bus;
        r.program_counter = pc_model;
        r.instruction     = ir_model;
        r.memory_address  = mar_model;
        r.accumulator     = a_model;
        r.operand_reg     = b_model;
        r.halted          = halt_model;
    endtask

    task automatic check_field(string name, logic [14:0] want, logic [14:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // monitor: predicts accepted words and checks returned ones
    always @(posedge clk)
    begin
        result_t want;
        result_t predicted;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no expected result pending");
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("control_word", want.control_word, result_word.control_word);
                    check_field("bus_value", 15'(want.bus_value),
                                15'(result_word.bus_value));
                    check_field("program_counter", 15'(want.program_counter),
                                15'(result_word.program_counter));
                    check_field("instruction", 15'(want.instruction),
                                15'(result_word.instruction));
                    check_field("memory_address", 15'(want.memory_address),
                                15'(result_word.memory_address));
                    check_field("accumulator", 15'(want.accumulator),
                                15'(result_word.accumulator));
                    check_field("operand_reg", 15'(want.operand_reg),
                                15'(result_word.operand_reg));
                    check_field("halted", 15'(want.halted), 15'(result_word.halted));
                end
            end
            if (item_valid && item_ready)
            begin
                execute_word(item_word, predicted);
                expected_results.push_back(predicted);
                words_accepted++;
            end
        end
    end

    // driver: bursts of words with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (item_valid && (words_accepted != words_sent))
        begin
            // hold the word until it is taken
        end
        else if (gap_left > 0)
        begin
            item_valid <= 1'b0;
            gap_left--;
        end
        else if (pending_words.size() > 0)
        begin
            item_word  <= pending_words.pop_front();
            item_valid <= 1'b1;
            words_sent++;
            if (burst_left <= 1)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
                burst_left--;
        end
        else
            item_valid <= 1'b0;
    end

    // receiver: random stalls whose density changes at random
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            result_ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end
        else
            result_ready <= 1'b1;
        if (mode_left <= 0)
        begin
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 15;
                default: stall_pct = 50;
            endcase
            mode_left = $urandom_range(16, 96);
        end
        else
            mode_left--;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("microcoded_bus_cpu_step_unit_test: FAIL");
        $finish;
    end

    task automatic push_word(logic op, addr_t addr, logic [7:0] data);
        item_t w;
        w.operation    = op;
        w.load_address = addr;
        w.load_data    = data;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_tick();
        push_word(OPER_TICK, addr_t'($urandom), 8'($urandom));
    endtask

    task automatic wait_idle();
        while (words_accepted != words_queued || expected_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] data_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // an address outside the n instructions starting at base
    function automatic addr_t outside_addr(addr_t base, int n);
        return addr_t'(base + n + $urandom_range(0, RAM_DEPTH - 1 - n));
    endfunction

    // one program segment: fresh instructions at pc, then whole instructions
    // of ticks so the segment ends on a fetch boundary
    task automatic run_segment();
        addr_t      base;
        int         n_instr;
        int         pick;
        logic [3:0] opc;
        addr_t      operand;
        wait_idle();
        base    = pc_model;
        n_instr = $urandom_range(1, 8);
        for (int i = 0; i < n_instr; i++)
        begin
            pick    = $urandom_range(0, 99);
            operand = addr_t'($urandom);
            if (pick < 30)
                opc = OP_LDA;
            else if (pick < 55)
                opc = OP_ADD;
            else if (pick < 80)
            begin
                opc     = OP_STA;
                operand = outside_addr(base, n_instr);
            end
            else
                opc = 4'($urandom_range(OP_ADD + 1, 15));
            push_word(OPER_LOAD, addr_t'(base + i), {opc, operand});
        end
        repeat ($urandom_range(0, 5))
            push_word(OPER_LOAD, outside_addr(base, n_instr), data_byte());
        repeat (8 * n_instr)
        begin
            if ($urandom_range(0, 99) < 12)
                push_word(OPER_LOAD, outside_addr(base, n_instr), data_byte());
            push_tick();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item_word    = '0;
        result_ready = 1'b0;
        burst_left   = 0;
        gap_left     = 0;
        stall_left   = 0;
        stall_pct    = 0;
        mode_left    = 0;
        pc_model     = '0;
        mar_model    = '0;
        ir_model     = '0;
        a_model      = '0;
        b_model      = '0;
        step_model   = '0;
        halt_model   = 1'b0;
        foreach (ram_model[i])
            ram_model[i] = '0;
        words_queued   = 0;
        words_accepted = 0;
        words_sent     = 0;
        error_count    = 0;
        cycle_count    = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: load, add with wraparound, store
        push_word(OPER_LOAD, 4'h0, {OP_LDA, 4'hf});
        push_word(OPER_LOAD, 4'h1, {OP_ADD, 4'hf});
        push_word(OPER_LOAD, 4'h2, {OP_STA, 4'he});
        push_word(OPER_LOAD, 4'hf, 8'hff);
        repeat (24)
            push_tick();

        while (words_queued < TARGET_WORDS)
            run_segment();

        // halt, then ticks and loads while halted
        wait_idle();
        push_word(OPER_LOAD, pc_model, {OP_HLT, 4'($urandom)});
        repeat (10)
            push_tick();
        push_word(OPER_LOAD, 4'hf, 8'ha5);
        push_word(OPER_LOAD, 4'h0, 8'h00);
        repeat (4)
            push_tick();

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("microcoded_bus_cpu_step_unit_test: PASS");
        else
            $display("microcoded_bus_cpu_step_unit_test: FAIL");
        $finish;
    end

endmodule
